[sv/hrl_pkg.sv]
`default_nettype none
package hrl_pkg;

   localparam int CORDIC_STEPS_DEF = 24;
   localparam int TAB_LEN          = 32;
   localparam int CSR_ADDR_W       = 3;

   // Q3.29 angles, carried at 42 bits through the limiter arithmetic
   localparam logic signed [41:0] PI_Q29      = 42'sd1686629684;
   localparam logic signed [41:0] TWO_PI_Q29  = 42'sd3373259368;
   localparam logic signed [41:0] TRUE_PI_Q29 = 42'sd1686629713;

   localparam logic [30:0] MIN_DISTANCE_RESET = 31'd6554;
   localparam logic [30:0] MAX_YAW_RATE_RESET = 31'd52707179;
   localparam logic [19:0] US_PER_S           = 20'd1000000;
   localparam logic [18:0] HALF_US_PER_S      = 19'd500000;

   typedef enum logic {
      CSR_MIN_DISTANCE = 1'b0,
      CSR_MAX_YAW_RATE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] offset_x;
      logic signed [31:0] offset_y;
      logic signed [31:0] offset_z;
      logic [19:0]        elapsed_us;
      logic               hold;
   } hrl_req_type;

   typedef struct packed {
      logic signed [31:0] heading;
      logic signed [31:0] heading_rate;
   } hrl_rsp_type;

   typedef logic [31:0] angle_tab_type [TAB_LEN];

   // unsigned quotient by shift and subtract, elaboration only
   function automatic longint unsigned udiv64(input longint unsigned num,
                                              input longint unsigned den);
      longint unsigned q;
      longint unsigned r;
      q = 64'd0;
      r = 64'd0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], num[b]};
         if (r >= den) begin
            r    = r - den;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // atan(2^-i) in Q3.29 from its power series, evaluated at elaboration
   function automatic angle_tab_type build_angle_tab();
      angle_tab_type     tab;
      longint unsigned   term;
      longint unsigned   sum;
      longint unsigned   k;
      tab[0] = 32'd421657428;
      for (int i = 1; i < TAB_LEN; i++) begin
         term = 64'd1 << (61 - i);
         sum  = 64'd0;
         k    = 64'd0;
         while (term != 64'd0) begin
            if (k[0]) begin
               sum -= udiv64(term, 2 * k + 1);
            end else begin
               sum += udiv64(term, 2 * k + 1);
            end
            term = term >> (2 * i);
            k++;
         end
         tab[i] = 32'((sum + 64'h8000_0000) >> 32);
      end
      return tab;
   endfunction

   localparam angle_tab_type ANGLE_TAB = build_angle_tab();

endpackage
`default_nettype wire

[sv/heading_rate_limiter.sv]
// A hold item goes from accept straight to the done state; a normal item runs the sequencer below.
// One item at a time; ready returns in the same cycle that the result becomes valid,
// and a finished item waits until the result register is free.
// Time goes to the bit-serial multiplier (one multiplier bit per cycle), two 56-step
// restoring divides (limit and rate) and the CORDIC loop (one step per cycle).
// Reset (synchronous, active high): held heading and rate to zero, registers to defaults.
`default_nettype none
module heading_rate_limiter #(
   parameter int CORDIC_STEPS = hrl_pkg::CORDIC_STEPS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  hrl_pkg::hrl_req_type            req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output hrl_pkg::hrl_rsp_type            rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [hrl_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import hrl_pkg::*;

   localparam int STEP_W    = $clog2(CORDIC_STEPS + 1);
   localparam int DIV_STEPS = 56;

   // Sequencer: squares -> radius compare -> (normalize -> CORDIC) -> limit M ->
   // decide branch -> (rate multiply/divide) -> average -> result register; hold skips to the result.
   typedef enum logic [3:0] {
      S_IDLE, S_SQUARE, S_RADIUS, S_NORM, S_CORDIC, S_LIMIT_MUL, S_LIMIT_DIV,
      S_DECIDE, S_RATE_MUL, S_RATE_DIV, S_AVERAGE, S_DONE
   } state_type;

   state_type           state_ff;
   logic [30:0]         min_distance_ff;
   logic [30:0]         max_yaw_rate_ff;
   logic signed [31:0]  held_heading_ff;
   logic signed [31:0]  held_rate_ff;
   hrl_req_type         in_ff;

   // bit-serial multiplier: one bit of mul_b per cycle
   logic [63:0]         mul_a_ff;
   logic [31:0]         mul_b_ff;
   logic [63:0]         mul_acc_ff;
   logic [1:0]          sq_sel_ff;
   logic [63:0]         dist_sum_ff;

   // CORDIC datapath
   logic signed [33:0]  cx_ff;
   logic signed [33:0]  cy_ff;
   logic signed [33:0]  cz_ff;
   logic [STEP_W-1:0]   step_ff;

   // restoring divider: dividend shifts out, quotient shifts in
   logic [55:0]         div_num_ff;
   logic [24:0]         div_rem_ff;
   logic [24:0]         div_den_ff;
   logic [5:0]          div_cnt_ff;

   logic signed [31:0]  target_ff;
   logic [36:0]         limit_ff;
   logic signed [41:0]  yaw_ff;
   logic signed [34:0]  raw_ff;
   logic                rate_neg_ff;
   logic signed [31:0]  new_heading_ff;
   logic signed [31:0]  new_rate_ff;
   logic                update_ff;
   logic                rsp_valid_ff;
   hrl_rsp_type         rsp_data_ff;

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      return v[31] ? 32'(-v) : 32'(v);
   endfunction

   // ---------------- configuration port ----------------
   logic csr_write;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_distance_ff <= MIN_DISTANCE_RESET;
         max_yaw_rate_ff <= MAX_YAW_RATE_RESET;
      end else if (csr_write) begin
         case (csr_index_type'(csr_paddr[2]))
            CSR_MIN_DISTANCE: min_distance_ff <= csr_pwdata[30:0];
            CSR_MAX_YAW_RATE: max_yaw_rate_ff <= csr_pwdata[30:0];
            default:          min_distance_ff <= min_distance_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index_type'(csr_paddr[2]))
         CSR_MIN_DISTANCE: csr_prdata = {1'b0, min_distance_ff};
         CSR_MAX_YAW_RATE: csr_prdata = {1'b0, max_yaw_rate_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   // ---------------- shared serial units ----------------
   logic        mul_done;
   logic [63:0] mul_acc_in;
   assign mul_done   = (mul_b_ff == 32'd0);
   assign mul_acc_in = mul_b_ff[0] ? mul_acc_ff + mul_a_ff : mul_acc_ff;

   logic        div_done;
   logic [25:0] div_shift;
   logic        div_qbit;
   logic [24:0] div_rem_in;
   assign div_done   = (div_cnt_ff == 6'(DIV_STEPS));
   assign div_shift  = {div_rem_ff, div_num_ff[55]};
   assign div_qbit   = (div_shift >= {1'b0, div_den_ff});
   assign div_rem_in = div_qbit ? 25'(div_shift - {1'b0, div_den_ff}) : div_shift[24:0];

   // ---------------- CORDIC step ----------------
   logic signed [33:0] cr_dx, cr_dy, cr_ang;
   logic signed [33:0] cz_clamp;
   logic               norm_small;
   assign cr_dx  = cx_ff >>> step_ff[4:0];
   assign cr_dy  = cy_ff >>> step_ff[4:0];
   assign cr_ang = $signed({2'b00, ANGLE_TAB[step_ff[4:0]]});
   assign norm_small = (cx_ff < 34'sd1073741824) && (cy_ff < 34'sd1073741824)
                       && (cy_ff > -34'sd1073741824);

   always_comb begin
      cz_clamp = cz_ff;
      if (42'(cz_ff) > TRUE_PI_Q29)  cz_clamp = 34'(TRUE_PI_Q29);
      if (42'(cz_ff) < -TRUE_PI_Q29) cz_clamp = 34'(-TRUE_PI_Q29);
   end

   // ---------------- limiter decision ----------------
   logic signed [41:0] dc_t, dc_l, dc_m, dc_r, dc_d, dc_lm, dc_lp, dc_yaw;
   logic signed [34:0] dc_raw;
   logic               dc_need;
   logic [32:0]        dc_dmag;

   always_comb begin
      dc_t = 42'(target_ff);
      dc_l = 42'(held_heading_ff);
      dc_m = $signed({5'd0, limit_ff});
      dc_r = $signed({11'd0, max_yaw_rate_ff});
      dc_d = dc_t - dc_l;
      dc_lm = dc_l - dc_m;
      if (dc_lm < -PI_Q29) dc_lm = dc_lm + TWO_PI_Q29;
      dc_lp = dc_l + dc_m;
      if (dc_lp > PI_Q29) dc_lp = dc_lp - TWO_PI_Q29;
      dc_need = 1'b0;
      if (dc_d > PI_Q29) begin
         // wrapped change is negative
         dc_yaw = (dc_d - TWO_PI_Q29 < -dc_m) ? dc_lm : dc_t;
         dc_raw = 35'(-dc_r);
      end else if (dc_d < -PI_Q29) begin
         dc_yaw = (dc_d + TWO_PI_Q29 > dc_m) ? dc_lp : dc_t;
         dc_raw = 35'(dc_r);
      end else if (dc_d < -dc_m) begin
         dc_yaw = dc_lm;
         dc_raw = 35'(-dc_r);
      end else if (dc_d > dc_m) begin
         dc_yaw = dc_lp;
         dc_raw = 35'(dc_r);
      end else begin
         dc_yaw  = dc_t;
         dc_raw  = 35'sd0;
         dc_need = 1'b1;
      end
      if (in_ff.elapsed_us == 20'd0) dc_raw = 35'sd0;
      dc_dmag = 33'(dc_d < 0 ? -dc_d : dc_d);
   end

   // ---------------- averaging ----------------
   logic signed [41:0] av_diff, av_abs, av_sum, av_h;
   logic signed [35:0] av_rs, av_r;
   logic signed [31:0] av_heading, av_rate;

   always_comb begin
      av_diff = yaw_ff - dc_l;
      av_abs  = av_diff < 0 ? -av_diff : av_diff;
      av_sum  = yaw_ff + dc_l;
      av_h    = (av_abs <= dc_m) ? (av_sum >>> 1) : yaw_ff;
      if (av_h > TRUE_PI_Q29)  av_h = TRUE_PI_Q29;
      if (av_h < -TRUE_PI_Q29) av_h = -TRUE_PI_Q29;
      av_heading = 32'(av_h);
      av_rs = 36'(held_rate_ff) + 36'(raw_ff);
      av_r  = av_rs >>> 1;
      if (av_r > 36'sd2147483647)       av_rate = 32'sh7FFF_FFFF;
      else if (av_r < -36'sd2147483648) av_rate = 32'sh8000_0000;
      else                              av_rate = 32'(av_r);
   end

   logic [34:0] rq_sat;
   assign rq_sat = (div_num_ff > 56'h2_0000_0000) ? 35'h2_0000_0000 : div_num_ff[34:0];

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         held_heading_ff <= 32'sd0;
         held_rate_ff    <= 32'sd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         // in S_DONE the result register is handled by the commit below
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  in_ff <= req_data;
                  if (req_data.hold) begin
                     new_heading_ff <= held_heading_ff;
                     new_rate_ff    <= 32'sd0;
                     update_ff      <= 1'b0;
                     state_ff       <= S_DONE;
                  end else begin
                     mul_a_ff   <= {32'd0, mag32(req_data.offset_x)};
                     mul_b_ff   <= mag32(req_data.offset_x);
                     mul_acc_ff <= 64'd0;
                     sq_sel_ff  <= 2'd0;
                     state_ff   <= S_SQUARE;
                  end
               end
            end
            S_SQUARE: begin
               // x^2 + y^2 + z^2 builds up in one accumulator
               if (!mul_done) begin
                  mul_acc_ff <= mul_acc_in;
                  mul_a_ff   <= mul_a_ff << 1;
                  mul_b_ff   <= mul_b_ff >> 1;
               end else begin
                  case (sq_sel_ff)
                     2'd0: begin
                        mul_a_ff  <= {32'd0, mag32(in_ff.offset_y)};
                        mul_b_ff  <= mag32(in_ff.offset_y);
                        sq_sel_ff <= 2'd1;
                     end
                     2'd1: begin
                        mul_a_ff  <= {32'd0, mag32(in_ff.offset_z)};
                        mul_b_ff  <= mag32(in_ff.offset_z);
                        sq_sel_ff <= 2'd2;
                     end
                     default: begin
                        dist_sum_ff <= mul_acc_ff;
                        mul_acc_ff  <= 64'd0;
                        mul_a_ff    <= {33'd0, min_distance_ff};
                        mul_b_ff    <= {1'b0, min_distance_ff};
                        state_ff    <= S_RADIUS;
                     end
                  endcase
               end
            end
            S_RADIUS: begin
               if (!mul_done) begin
                  mul_acc_ff <= mul_acc_in;
                  mul_a_ff   <= mul_a_ff << 1;
                  mul_b_ff   <= mul_b_ff >> 1;
               end else if ((dist_sum_ff > mul_acc_ff)
                            && !(in_ff.offset_x == 32'sd0 && in_ff.offset_y == 32'sd0)) begin
                  // left half plane: rotate by pi and start z at +-pi
                  if (in_ff.offset_x[31]) begin
                     cx_ff <= -34'(in_ff.offset_x);
                     cy_ff <= -34'(in_ff.offset_y);
                     cz_ff <= in_ff.offset_y[31] ? 34'(-TRUE_PI_Q29) : 34'(TRUE_PI_Q29);
                  end else begin
                     cx_ff <= 34'(in_ff.offset_x);
                     cy_ff <= 34'(in_ff.offset_y);
                     cz_ff <= 34'sd0;
                  end
                  state_ff <= S_NORM;
               end else begin
                  target_ff  <= (dist_sum_ff > mul_acc_ff) ? 32'sd0 : held_heading_ff;
                  mul_a_ff   <= {33'd0, max_yaw_rate_ff};
                  mul_b_ff   <= {12'd0, in_ff.elapsed_us};
                  mul_acc_ff <= 64'd0;
                  state_ff   <= S_LIMIT_MUL;
               end
            end
            S_NORM: begin
               if (norm_small) begin
                  cx_ff <= cx_ff <<< 1;
                  cy_ff <= cy_ff <<< 1;
               end else begin
                  step_ff  <= '0;
                  state_ff <= S_CORDIC;
               end
            end
            S_CORDIC: begin
               if (step_ff == STEP_W'(CORDIC_STEPS)) begin
                  target_ff  <= 32'(cz_clamp);
                  mul_a_ff   <= {33'd0, max_yaw_rate_ff};
                  mul_b_ff   <= {12'd0, in_ff.elapsed_us};
                  mul_acc_ff <= 64'd0;
                  state_ff   <= S_LIMIT_MUL;
               end else begin
                  if (!cy_ff[33]) begin
                     cx_ff <= cx_ff + cr_dy;
                     cy_ff <= cy_ff - cr_dx;
                     cz_ff <= cz_ff + cr_ang;
                  end else begin
                     cx_ff <= cx_ff - cr_dy;
                     cy_ff <= cy_ff + cr_dx;
                     cz_ff <= cz_ff - cr_ang;
                  end
                  step_ff <= step_ff + 1'b1;
               end
            end
            S_LIMIT_MUL: begin
               if (!mul_done) begin
                  mul_acc_ff <= mul_acc_in;
                  mul_a_ff   <= mul_a_ff << 1;
                  mul_b_ff   <= mul_b_ff >> 1;
               end else begin
                  // M = (R * us * 32 + 500000) / 1000000
                  div_num_ff <= {mul_acc_ff[50:0], 5'd0} + {37'd0, HALF_US_PER_S};
                  div_den_ff <= {5'd0, US_PER_S};
                  div_rem_ff <= 25'd0;
                  div_cnt_ff <= 6'd0;
                  state_ff   <= S_LIMIT_DIV;
               end
            end
            S_LIMIT_DIV: begin
               if (!div_done) begin
                  div_rem_ff <= div_rem_in;
                  div_num_ff <= {div_num_ff[54:0], div_qbit};
                  div_cnt_ff <= div_cnt_ff + 1'b1;
               end else begin
                  limit_ff <= div_num_ff[36:0];
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               yaw_ff <= dc_yaw;
               raw_ff <= dc_raw;
               if (dc_need && in_ff.elapsed_us != 20'd0) begin
                  rate_neg_ff <= (dc_d < 0);
                  mul_a_ff    <= {31'd0, dc_dmag};
                  mul_b_ff    <= {12'd0, US_PER_S};
                  mul_acc_ff  <= 64'd0;
                  state_ff    <= S_RATE_MUL;
               end else begin
                  state_ff <= S_AVERAGE;
               end
            end
            S_RATE_MUL: begin
               if (!mul_done) begin
                  mul_acc_ff <= mul_acc_in;
                  mul_a_ff   <= mul_a_ff << 1;
                  mul_b_ff   <= mul_b_ff >> 1;
               end else begin
                  // rate = (|d| * 1e6 + 16 us) / (32 us), rounded half away from zero
                  div_num_ff <= mul_acc_ff[55:0] + {32'd0, in_ff.elapsed_us, 4'd0};
                  div_den_ff <= {in_ff.elapsed_us, 5'd0};
                  div_rem_ff <= 25'd0;
                  div_cnt_ff <= 6'd0;
                  state_ff   <= S_RATE_DIV;
               end
            end
            S_RATE_DIV: begin
               if (!div_done) begin
                  div_rem_ff <= div_rem_in;
                  div_num_ff <= {div_num_ff[54:0], div_qbit};
                  div_cnt_ff <= div_cnt_ff + 1'b1;
               end else begin
                  // beyond 2^33 the averaged rate saturates anyway
                  raw_ff   <= rate_neg_ff ? -$signed(rq_sat) : $signed(rq_sat);
                  state_ff <= S_AVERAGE;
               end
            end
            S_AVERAGE: begin
               new_heading_ff <= av_heading;
               new_rate_ff    <= av_rate;
               update_ff      <= 1'b1;
               state_ff       <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff             <= 1'b1;
                  rsp_data_ff.heading      <= new_heading_ff;
                  rsp_data_ff.heading_rate <= new_rate_ff;
                  if (update_ff) begin
                     held_heading_ff <= new_heading_ff;
                     held_rate_ff    <= new_rate_ff;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (42'(rsp_data.heading) <= TRUE_PI_Q29
                     && 42'(rsp_data.heading) >= -TRUE_PI_Q29))
      else $error("heading outside +-pi");

   a_held_commit: assert property (@(posedge clock) disable iff (reset)
      !$stable(held_heading_ff) |-> ($past(state_ff == S_DONE) || $past(reset)))
      else $error("held heading changed outside commit");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_DONE))
      else $error("result raised outside commit");

   a_cordic_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CORDIC) |-> (step_ff <= STEP_W'(CORDIC_STEPS)))
      else $error("CORDIC step count overrun");
`endif

endmodule
`default_nettype wire
